### rtl/carrier_tape_pocket_counter_assert.svh
// Assertion macros for the carrier tape pocket counter.
`ifndef CARRIER_TAPE_POCKET_COUNTER_ASSERT_SVH
`define CARRIER_TAPE_POCKET_COUNTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CTPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ctpc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CTPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ctpc: next-cycle check failed");

`endif

### rtl/ctpc_pkg.sv
`default_nettype none
package ctpc_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int OUT_BITS           = 16;
   localparam int RUN_BITS           = 8;
   localparam int THR_BITS           = 8;

   localparam logic [THR_BITS-1:0] LEAD_RUN_RESET  = 8'd3;
   localparam logic [THR_BITS-1:0] TRAIL_RUN_RESET = 8'd5;

   // register indexes on the csr port
   localparam logic CSR_LEAD_RUN  = 1'b0;
   localparam logic CSR_TRAIL_RUN = 1'b1;

   // request function codes
   localparam logic FUNC_HOLE  = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      REGION_START = 2'd0,
      REGION_LEAD  = 2'd1,
      REGION_CHIPS = 2'd2,
      REGION_TRAIL = 2'd3
   } region_type;

endpackage
`default_nettype wire

### rtl/carrier_tape_pocket_counter.sv
// The result word is registered: an accepted request word passes the input register, then
// the result register.
// Throughput: one word per cycle while the response is not stalled; the counter update is a single pass of short logic.
// A stalled response holds the result register, and the input register backs up behind it.
// Reset (synchronous, active high) clears all counts, the region, run and phase, and
// loads the thresholds with 3 (leading) and 5 (trailing).
`default_nettype none
`include "carrier_tape_pocket_counter_assert.svh"

module carrier_tape_pocket_counter #(
   parameter int COUNT_BITS = ctpc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_func,
   input  wire logic                              req_chip_present,
   input  wire logic                              req_count_enable,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ctpc_pkg::OUT_BITS-1:0]          rsp_holes_seen,
   output logic [ctpc_pkg::OUT_BITS-1:0]          rsp_lead_empties,
   output logic [ctpc_pkg::OUT_BITS-1:0]          rsp_chip_total,
   output logic [ctpc_pkg::OUT_BITS-1:0]          rsp_middle_empties,
   output logic [ctpc_pkg::OUT_BITS-1:0]          rsp_trail_empties,
   output logic [1:0]                             rsp_region,
   output logic                                   rsp_pocket_sampled,
   output logic                                   rsp_chip_in_trail_error,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic [ctpc_pkg::THR_BITS-1:0]     csr_wdata
);

   localparam int RB = ctpc_pkg::RUN_BITS;
   localparam int OB = ctpc_pkg::OUT_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [RB-1:0]         RUN_MAX = '1;

   // thresholds
   logic [ctpc_pkg::THR_BITS-1:0] lead_thr_ff, trail_thr_ff;

   // input register
   logic s1_valid_ff, s1_valid_in;
   logic s1_func_ff, s1_chip_ff, s1_en_ff;

   // counting state
   ctpc_pkg::region_type region_ff, region_in;
   logic [COUNT_BITS-1:0] hole_ff, hole_in;
   logic [COUNT_BITS-1:0] lead_ff, lead_in;
   logic [COUNT_BITS-1:0] chip_ff, chip_in;
   logic [COUNT_BITS-1:0] middle_ff, middle_in;
   logic [COUNT_BITS-1:0] trail_ff, trail_in;
   logic [RB-1:0]         run_ff, run_in;
   logic                  phase_ff, phase_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [OB-1:0] holes_out_ff, lead_out_ff, chip_out_ff, middle_out_ff, trail_out_ff;
   logic [1:0]    region_out_ff;
   logic          sampled_out_ff, err_out_ff;

   logic out_load, step, sample, sampled, err;
   logic [RB-1:0] run_bump;
   logic [COUNT_BITS:0] middle_sum;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign step      = s1_valid_ff && out_load;
   assign req_ready = !s1_valid_ff || out_load;

   assign sample   = (s1_func_ff == ctpc_pkg::FUNC_HOLE) && s1_en_ff && !phase_ff;
   assign run_bump = (run_ff == RUN_MAX) ? run_ff : run_ff + 1'b1;
   assign middle_sum = {1'b0, middle_ff} + (COUNT_BITS+1)'(run_ff);

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [OB-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
      logic [31:0] ext;
      ext = 32'(v);
      return (ext > 32'h0000_FFFF) ? '1 : ext[OB-1:0];
   endfunction

   // next region
   always_comb begin
      region_in = region_ff;
      if (s1_func_ff == ctpc_pkg::FUNC_CLEAR) begin
         region_in = ctpc_pkg::REGION_START;
      end else if (sample) begin
         unique case (region_ff)
            ctpc_pkg::REGION_START,
            ctpc_pkg::REGION_LEAD: begin
               if (s1_chip_ff) begin
                  region_in = ctpc_pkg::REGION_CHIPS;
               end else if (region_ff == ctpc_pkg::REGION_START && run_bump >= lead_thr_ff) begin
                  region_in = ctpc_pkg::REGION_LEAD;
               end
            end
            ctpc_pkg::REGION_CHIPS: begin
               if (!s1_chip_ff && run_bump >= trail_thr_ff) begin
                  region_in = ctpc_pkg::REGION_TRAIL;
               end
            end
            ctpc_pkg::REGION_TRAIL: region_in = ctpc_pkg::REGION_TRAIL;
            default: region_in = region_ff;
         endcase
      end
   end

   // counter updates and per-word flags
   always_comb begin
      hole_in   = hole_ff;
      lead_in   = lead_ff;
      chip_in   = chip_ff;
      middle_in = middle_ff;
      trail_in  = trail_ff;
      run_in    = run_ff;
      phase_in  = phase_ff;
      sampled   = 1'b0;
      err       = 1'b0;
      if (s1_func_ff == ctpc_pkg::FUNC_CLEAR) begin
         hole_in   = '0;
         lead_in   = '0;
         chip_in   = '0;
         middle_in = '0;
         trail_in  = '0;
         run_in    = '0;
         phase_in  = 1'b0;
      end else if (s1_en_ff) begin
         hole_in  = sat_inc(hole_ff);
         phase_in = !phase_ff;
         if (sample) begin
            sampled = 1'b1;
            unique case (region_ff)
               ctpc_pkg::REGION_START,
               ctpc_pkg::REGION_LEAD: begin
                  if (s1_chip_ff) begin
                     chip_in = sat_inc(chip_ff);
                     run_in  = '0;
                  end else begin
                     lead_in = sat_inc(lead_ff);
                     run_in  = run_bump;
                  end
               end
               ctpc_pkg::REGION_CHIPS: begin
                  if (s1_chip_ff) begin
                     middle_in = middle_sum[COUNT_BITS] ? CNT_MAX : middle_sum[COUNT_BITS-1:0];
                     chip_in   = sat_inc(chip_ff);
                     run_in    = '0;
                  end else begin
                     run_in = run_bump;
                     if (run_bump >= trail_thr_ff) begin
                        trail_in = COUNT_BITS'(run_bump);
                     end
                  end
               end
               ctpc_pkg::REGION_TRAIL: begin
                  if (s1_chip_ff) begin
                     err = 1'b1;
                  end else begin
                     trail_in = sat_inc(trail_ff);
                  end
               end
               default: err = 1'b0;
            endcase
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_thr_ff  <= ctpc_pkg::LEAD_RUN_RESET;
         trail_thr_ff <= ctpc_pkg::TRAIL_RUN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ctpc_pkg::CSR_LEAD_RUN:  lead_thr_ff  <= csr_wdata;
            ctpc_pkg::CSR_TRAIL_RUN: trail_thr_ff <= csr_wdata;
            default: lead_thr_ff <= lead_thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         region_ff    <= ctpc_pkg::REGION_START;
         hole_ff      <= '0;
         lead_ff      <= '0;
         chip_ff      <= '0;
         middle_ff    <= '0;
         trail_ff     <= '0;
         run_ff       <= '0;
         phase_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            region_ff <= region_in;
            hole_ff   <= hole_in;
            lead_ff   <= lead_in;
            chip_ff   <= chip_in;
            middle_ff <= middle_in;
            trail_ff  <= trail_in;
            run_ff    <= run_in;
            phase_ff  <= phase_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_func_ff <= req_func;
         s1_chip_ff <= req_chip_present;
         s1_en_ff   <= req_count_enable;
      end
      if (step) begin
         holes_out_ff   <= clamp_out(hole_in);
         lead_out_ff    <= clamp_out(lead_in);
         chip_out_ff    <= clamp_out(chip_in);
         middle_out_ff  <= clamp_out(middle_in);
         trail_out_ff   <= clamp_out(trail_in);
         region_out_ff  <= region_in;
         sampled_out_ff <= sampled;
         err_out_ff     <= err;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_holes_seen          = holes_out_ff;
   assign rsp_lead_empties        = lead_out_ff;
   assign rsp_chip_total          = chip_out_ff;
   assign rsp_middle_empties      = middle_out_ff;
   assign rsp_trail_empties       = trail_out_ff;
   assign rsp_region              = region_out_ff;
   assign rsp_pocket_sampled      = sampled_out_ff;
   assign rsp_chip_in_trail_error = err_out_ff;

   `CTPC_ASSERT_NOW(a_err_needs_sample, clock, reset,
      rsp_valid && rsp_chip_in_trail_error, rsp_pocket_sampled)
   `CTPC_ASSERT_NOW(a_err_only_in_trail, clock, reset,
      rsp_valid && rsp_chip_in_trail_error, rsp_region == 2'(ctpc_pkg::REGION_TRAIL))
   `CTPC_ASSERT_NEXT(a_clear_zeroes, clock, reset,
      step && s1_func_ff == ctpc_pkg::FUNC_CLEAR,
      hole_ff == '0 && phase_ff == 1'b0 && region_ff == ctpc_pkg::REGION_START)
   `CTPC_ASSERT_NEXT(a_phase_toggles, clock, reset,
      step && s1_func_ff == ctpc_pkg::FUNC_HOLE && s1_en_ff,
      phase_ff != $past(phase_ff))

endmodule
`default_nettype wire
